/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i while out of reset.
`define TCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge of clk_i, reset included.
`define TCCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/tccs_pkg.sv */
// Package: constants, command codes, control types and index helper for the text console.
`default_nettype none

package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CMD_W  = 2;

  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [POS_W-1:0] CELL_COUNT = POS_W'(CELLS);
  localparam logic [POS_W-1:0] COPY_COUNT = POS_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] ROW_STRIDE = POS_W'(COLUMNS);

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic copy;
    logic init;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear;
    logic scroll;
    logic scan_done;
  } ctl_sts_t;

  function automatic logic [POS_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [POS_W-1:0] base;
    base = POS_W'(row) * ROW_STRIDE;
    return base + POS_W'(col);
  endfunction

endpackage

`default_nettype wire

/* hdl/tccs_ctrl.sv */
// Controller: sequences reset fill, command execution, store sweeps and result hand-off.
`default_nettype none

module tccs_ctrl
  import tccs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      cmd_o
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       copy_q, copy_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.scan     = (state_q == S_INIT) || (state_q == S_SCAN);
    cmd_o.copy     = (state_q == S_SCAN) && copy_q;
    cmd_o.init     = (state_q == S_INIT);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    copy_d  = copy_q;
    unique case (state_q)
      S_INIT: begin
        if (sts_i.scan_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        copy_d = sts_i.scroll;
        if (sts_i.clear || sts_i.scroll) state_d = S_SCAN;
        else state_d = S_DONE;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      copy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      copy_q      <= copy_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/tccs_datapath.sv */
// Datapath: cell store, cursor, attribute, item and result registers.
`default_nettype none

module tccs_datapath
  import tccs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctl_cmd_t          cmd_i,
  output ctl_sts_t               sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [ATTR_W-1:0] cfg_data_i,
  input  wire logic [CMD_W-1:0]  cmd_code_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [POS_W-1:0]  read_address_i,
  output logic [ROW_W-1:0]       cursor_row_o,
  output logic [COL_W-1:0]       cursor_column_o,
  output logic [POS_W-1:0]       cursor_position_o,
  output logic [CELL_W-1:0]      cell_data_o,
  output logic                   scrolled_o
);

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [POS_W-1:0]  scan_q;
  logic              scroll_q, scroll_d;

  logic [CMD_W-1:0]  op_q;
  logic [CHAR_W-1:0] char_q;
  logic [POS_W-1:0]  addr_q;

  logic [ROW_W-1:0]  ex_row;
  logic [COL_W-1:0]  ex_col;
  logic [CELL_W-1:0] ex_data;
  logic              ex_we;
  logic [CELL_W-1:0] blank;
  logic [POS_W-1:0]  scan_wa;

  logic              we;
  logic [POS_W-1:0]  waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [POS_W-1:0]  raddr;

  assign blank   = cmd_i.init ? CELL_RESET : {attr_q, CH_SPACE};
  assign scan_wa = scan_q - POS_W'(1);

  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    scroll_d = 1'b0;
    ex_we    = 1'b0;
    ex_row   = row_q;
    ex_col   = col_q;
    ex_data  = {attr_q, char_q};
    if (op_q == CMD_CLEAR) begin
      row_d = '0;
      col_d = '0;
    end else if (op_q == CMD_PUT) begin
      priority if (char_q == CH_NEWLINE) begin
        col_d = '0;
        if (row_q == LAST_ROW) scroll_d = 1'b1;
        else row_d = row_q + ROW_W'(1);
      end else if (char_q == CH_RETURN) begin
        col_d = '0;
      end else if (char_q == CH_BACKSPACE) begin
        ex_data = {attr_q, CH_SPACE};
        if (col_q != '0) begin
          col_d  = col_q - COL_W'(1);
          ex_col = col_d;
          ex_we  = 1'b1;
        end else if (row_q != '0) begin
          row_d  = row_q - ROW_W'(1);
          col_d  = LAST_COL;
          ex_row = row_d;
          ex_col = col_d;
          ex_we  = 1'b1;
        end
      end else begin
        ex_we = 1'b1;
        if (col_q == LAST_COL) begin
          col_d = '0;
          if (row_q == LAST_ROW) scroll_d = 1'b1;
          else row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  assign sts_o.clear     = (op_q == CMD_CLEAR);
  assign sts_o.scroll    = scroll_d;
  assign sts_o.scan_done = (scan_q == CELL_COUNT);

  always_comb begin
    we    = 1'b0;
    waddr = scan_wa;
    wdata = blank;
    re    = 1'b0;
    raddr = addr_q;
    if (cmd_i.scan) begin
      we    = (scan_q != '0);
      raddr = scan_q + ROW_STRIDE;
      re    = cmd_i.copy && (scan_q < COPY_COUNT);
      if (cmd_i.copy && (scan_wa < COPY_COUNT)) wdata = rdata_q;
    end else if (cmd_i.exec) begin
      we    = ex_we;
      waddr = cell_index(ex_row, ex_col);
      wdata = ex_data;
      re    = (op_q == CMD_READ) && (addr_q < CELL_COUNT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q   <= ATTR_RESET;
      row_q    <= '0;
      col_q    <= '0;
      scan_q   <= '0;
      scroll_q <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_data_i;
      if (cmd_i.exec) begin
        row_q    <= row_d;
        col_q    <= col_d;
        scroll_q <= scroll_d;
      end
      if (cmd_i.scan) scan_q <= scan_q + POS_W'(1);
      else scan_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= cmd_code_i;
      char_q <= char_code_i;
      addr_q <= read_address_i;
    end
    if (cmd_i.out_load) begin
      cursor_row_o      <= row_q;
      cursor_column_o   <= col_q;
      cursor_position_o <= cell_index(row_q, col_q);
      cell_data_o       <= ((op_q == CMD_READ) && (addr_q < CELL_COUNT)) ? rdata_q : '0;
      scrolled_o        <= scroll_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/text_console_cursor_scroll_top.sv */
// Top level: text console with cursor, scrolling and an 80 x 25 cell store.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    cmd_i, char_code_i, read_address_i
//   result    out_valid_o / out_ready_i  cursor_row_o, cursor_column_o,
//                                        cursor_position_o, cell_data_o, scrolled_o
//   config    cfg_we_i                   cfg_data_i (attribute)
//
// Put, read and unused commands pass through the execute and done states to the result register, one store access.
// Clear and any put that scrolls add a sweep over the store port that rewrites all CELLS = 2000 cells.
// After reset a fill writes blanks to every cell; in_ready_o stays low meanwhile.
// A finished result waits in the output register while the next transfer is taken.
// Configuration writes are taken at any time, without wait.
`default_nettype none

module text_console_cursor_scroll_top
  import tccs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [POS_W-1:0]  read_address_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ROW_W-1:0]       cursor_row_o,
  output logic [COL_W-1:0]       cursor_column_o,
  output logic [POS_W-1:0]       cursor_position_o,
  output logic [CELL_W-1:0]      cell_data_o,
  output logic                   scrolled_o,
  input  wire logic              cfg_we_i,
  input  wire logic [ATTR_W-1:0] cfg_data_i
);

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  tccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (ctl_sts),
    .cmd_o       (ctl_cmd)
  );

  tccs_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctl_cmd),
    .sts_o             (ctl_sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_code_i        (cmd_i),
    .char_code_i       (char_code_i),
    .read_address_i    (read_address_i),
    .cursor_row_o      (cursor_row_o),
    .cursor_column_o   (cursor_column_o),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o),
    .scrolled_o        (scrolled_o)
  );

endmodule

`default_nettype wire

/* hdl/tccs_checker.sv */
// Checker on the top-level ports, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module tccs_checker
  import tccs_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [CMD_W-1:0]  cmd_i,
  input wire logic [CHAR_W-1:0] char_code_i,
  input wire logic [POS_W-1:0]  read_address_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [ROW_W-1:0]  cursor_row_o,
  input wire logic [COL_W-1:0]  cursor_column_o,
  input wire logic [POS_W-1:0]  cursor_position_o,
  input wire logic [CELL_W-1:0] cell_data_o,
  input wire logic              scrolled_o,
  input wire logic              cfg_we_i,
  input wire logic [ATTR_W-1:0] cfg_data_i
);

  logic [POS_W-1:0] exp_pos;
  logic             in_xfer;

  assign exp_pos = cell_index(cursor_row_o, cursor_column_o);
  assign in_xfer = in_valid_i && in_ready_o && (cmd_i != '0 || char_code_i != '0 ||
                   read_address_i != '0 || cfg_we_i || cfg_data_i != '0 || 1'b1);

  `TCCS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_position_o) && $stable(cell_data_o), "result changed while stalled")
  `TCCS_ASSERT(a_cursor_range, out_valid_o |-> cursor_row_o <= LAST_ROW && cursor_column_o <= LAST_COL, "cursor out of range")
  `TCCS_ASSERT(a_pos_match, out_valid_o |-> cursor_position_o == exp_pos, "linear cursor does not match row and column")
  `TCCS_ASSERT(a_scroll_bottom, out_valid_o && scrolled_o |-> cursor_row_o == LAST_ROW && cursor_column_o == '0 && cell_data_o == '0, "scroll left cursor off the bottom line start")
  `TCCS_ASSERT_ALWAYS(a_no_xfer_reset, !rst_ni |-> !in_xfer, "transfer taken in reset")

endmodule

bind text_console_cursor_scroll_top tccs_checker u_tccs_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// Testbench for the text console: directed and random commands against a predictor.
`timescale 1ns / 100ps

module testbench;
  import tccs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  addr;
  } console_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
    logic              scrolled;
  } cursor_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [POS_W-1:0]  read_address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [COL_W-1:0]  cursor_column_o;
  logic [POS_W-1:0]  cursor_position_o;
  logic [CELL_W-1:0] cell_data_o;
  logic              scrolled_o;
  logic              cfg_we_i = 1'b0;
  logic [ATTR_W-1:0] cfg_data_i = '0;

  logic [CELL_W-1:0] screen_model [CELLS];
  logic [ATTR_W-1:0] attr_reg = ATTR_RESET;
  int                cur_row = 0;
  int                cur_col = 0;

  console_cmd_t   pending_cmds[$];
  cursor_report_t expected_reports[$];
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    error_count = 0;

  text_console_cursor_scroll_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .char_code_i      (char_code_i),
    .read_address_i   (read_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_row_o     (cursor_row_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_position_o(cursor_position_o),
    .cell_data_o      (cell_data_o),
    .scrolled_o       (scrolled_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 40) $display("%0t ERROR: %s", $time, msg);
  endtask

  // advance to the next row, scrolling the store at the bottom
  function automatic logic line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    for (int i = COLUMNS; i < CELLS; i++) screen_model[i - COLUMNS] = screen_model[i];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {attr_reg, CH_SPACE};
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic cursor_report_t console_step(console_cmd_t c);
    cursor_report_t r;
    logic [CELL_W-1:0] rd_data;
    logic scrolled;
    int pos;
    rd_data = '0;
    scrolled = 1'b0;
    case (c.cmd)
      CMD_PUT: begin
        if (c.ch == CH_NEWLINE) begin
          scrolled = line_feed();
        end else if (c.ch == CH_RETURN) begin
          cur_col = 0;
        end else if (c.ch == CH_BACKSPACE) begin
          if (cur_col > 0 || cur_row > 0) begin
            if (cur_col > 0) begin
              cur_col--;
            end else begin
              cur_row--;
              cur_col = COLUMNS - 1;
            end
            screen_model[cur_row * COLUMNS + cur_col] = {attr_reg, CH_SPACE};
          end
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {attr_reg, c.ch};
          cur_col++;
          if (cur_col >= COLUMNS) scrolled = line_feed();
        end
      end
      CMD_CLEAR: begin
        cur_row = 0;
        cur_col = 0;
        foreach (screen_model[i]) screen_model[i] = {attr_reg, CH_SPACE};
      end
      CMD_READ: begin
        if (int'(c.addr) < CELLS) rd_data = screen_model[c.addr];
      end
      default: ;
    endcase
    pos = cur_row * COLUMNS + cur_col;
    r.row = ROW_W'(cur_row);
    r.col = COL_W'(cur_col);
    r.pos = POS_W'(pos);
    r.data = rd_data;
    r.scrolled = scrolled;
    return r;
  endfunction

  function automatic console_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                            logic [POS_W-1:0] addr);
    console_cmd_t c;
    c.cmd = op;
    c.ch = ch;
    c.addr = addr;
    return c;
  endfunction

  function automatic console_cmd_t random_cmd();
    int unsigned pick;
    logic [CHAR_W-1:0] junk;
    logic [POS_W-1:0] addr;
    pick = $urandom_range(999);
    junk = CHAR_W'($urandom);
    addr = POS_W'($urandom);
    if (pick < 5) return make_cmd(CMD_CLEAR, junk, addr);
    if (pick < 10) return make_cmd(CMD_UNUSED, junk, addr);
    if (pick < 80) return make_cmd(CMD_PUT, CH_NEWLINE, addr);
    if (pick < 110) return make_cmd(CMD_PUT, CH_RETURN, addr);
    if (pick < 140) return make_cmd(CMD_PUT, CH_BACKSPACE, addr);
    if (pick < 400) begin
      if (pick < 280) addr = POS_W'($urandom_range(CELLS - 1));
      else if (pick < 370) addr = POS_W'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
      return make_cmd(CMD_READ, junk, addr);
    end
    return make_cmd(CMD_PUT, junk, addr);
  endfunction

  // mostly single commands, now and then a long unbroken line that can force a wrap
  task automatic queue_random(int unsigned count);
    int unsigned n;
    int unsigned k;
    n = 0;
    while (n < count) begin
      if ($urandom_range(199) == 0) begin
        k = $urandom_range(90, 70);
        repeat (k) begin
          pending_cmds.push_back(make_cmd(CMD_PUT, CHAR_W'($urandom_range(255, 14)),
                                          POS_W'($urandom)));
        end
        n += k;
      end else begin
        pending_cmds.push_back(random_cmd());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_reports.size() != 0);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    attr_reg = value;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [ATTR_W-1:0] attr, int unsigned send_pct,
                           int unsigned recv_pct);
    write_attribute(attr);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(340);
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : command_driver
    console_cmd_t taken;
    console_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken.cmd = cmd_i;
        taken.ch = char_code_i;
        taken.addr = read_address_i;
        expected_reports.push_back(console_step(taken));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= nxt.cmd;
          char_code_i <= nxt.ch;
          read_address_i <= nxt.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    cursor_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          flag_error("result transfer with no command outstanding");
        end else begin
          want = expected_reports.pop_front();
          if (cursor_row_o !== want.row)
            flag_error($sformatf("cursor_row %0d, expected %0d", cursor_row_o, want.row));
          if (cursor_column_o !== want.col)
            flag_error($sformatf("cursor_column %0d, expected %0d", cursor_column_o, want.col));
          if (cursor_position_o !== want.pos)
            flag_error($sformatf("cursor_position %0d, expected %0d",
                                 cursor_position_o, want.pos));
          if (cell_data_o !== want.data)
            flag_error($sformatf("cell_data %h, expected %h", cell_data_o, want.data));
          if (scrolled_o !== want.scrolled)
            flag_error($sformatf("scrolled %b, expected %b", scrolled_o, want.scrolled));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    foreach (screen_model[i]) screen_model[i] = CELL_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, '0));
    pending_cmds.push_back(make_cmd(CMD_READ, 8'hFF, POS_W'(CELLS - 1)));
    pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, '1));
    pending_cmds.push_back(make_cmd(CMD_PUT, CH_BACKSPACE, '0));
    pending_cmds.push_back(make_cmd(CMD_UNUSED, 8'hFF, '1));
    pending_cmds.push_back(make_cmd(CMD_PUT, 8'hFF, '0));
    pending_cmds.push_back(make_cmd(CMD_PUT, CH_RETURN, '0));
    pending_cmds.push_back(make_cmd(CMD_PUT, CH_NEWLINE, '0));
    pending_cmds.push_back(make_cmd(CMD_PUT, CH_BACKSPACE, '0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 8'h00, '0));
    // walk down to the bottom row; the last newline scrolls
    repeat (ROWS - 1) pending_cmds.push_back(make_cmd(CMD_PUT, CH_NEWLINE, '0));
    pending_cmds.push_back(make_cmd(CMD_READ, 8'h00, POS_W'(CELLS - 1)));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 8'hFF, '1));
    wait_drained();

    run_phase(8'h00, 0, 0);
    run_phase(8'hFF, 65, 0);
    run_phase(ATTR_W'($urandom), 0, 65);
    run_phase(ATTR_W'($urandom), 35, 35);
    run_phase(ATTR_W'($urandom), 0, 0);

    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/tccs_pkg.sv
hdl/tccs_ctrl.sv
hdl/tccs_datapath.sv
hdl/text_console_cursor_scroll_top.sv
hdl/tccs_checker.sv
sim/testbench.sv
